@@ rtl/linear_regression_gradient_descent_top_macros.svh @@
// Assertion macros shared by the linear regression block.
// Included by the top level only.
`ifndef LINEAR_REGRESSION_GRADIENT_DESCENT_TOP_MACROS_SVH
`define LINEAR_REGRESSION_GRADIENT_DESCENT_TOP_MACROS_SVH
// Property that must hold at every clock edge outside reset.
`define LRGD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define LRGD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/lrgd_pkg.sv @@
// Shared types, constants and commands for the linear regression block.
// No dependencies.
`default_nettype none
package lrgd_pkg;
  localparam int MaxFeatures = 8;
  localparam int MaxSamples  = 1024;
  localparam int FIdxW = 4;
  localparam int SIdxW = 10;
  localparam int FAddrW = 13;

  localparam logic [1:0] KIND_WEIGHT  = 2'd0;
  localparam logic [1:0] KIND_FEATURE = 2'd1;
  localparam logic [1:0] KIND_TARGET  = 2'd2;
  localparam logic [1:0] KIND_START   = 2'd3;

  localparam logic [1:0] REG_RATE  = 2'd0;
  localparam logic [1:0] REG_ITER  = 2'd1;
  localparam logic [1:0] REG_FEAT  = 2'd2;
  localparam logic [1:0] REG_SAMP  = 2'd3;

  localparam logic signed [47:0] SumHi = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SumLo = 48'sh8000_0000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;       // store a load word
    logic             clr_acc;    // acc <= bias weight
    logic             mac_pred;   // acc += w[j]*x[i][j]
    logic             mac_grad;   // grad[j] += e*x[i][j] (or e for j=0)
    logic             clr_grad;
    logic             wr_pred;    // predictions[i] <= sat(acc)
    logic             err;        // e <= pred[i]-target[i]
    logic             upd_mul;    // prod <= grad[j]*rate
    logic             div_start;
    logic             wr_weight;  // w[j] <= sat(w[j]-quotient)
    logic [SIdxW-1:0] si;
    logic [FIdxW-1:0] fj;
  } lrgd_cmd_t;

  typedef struct packed {
    logic div_busy;
  } lrgd_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -65'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'(SumHi)) return SumHi;
    if (v < 50'(SumLo)) return SumLo;
    return v[47:0];
  endfunction
endpackage
`default_nettype wire

@@ rtl/linear_regression_gradient_descent_top.sv @@
// Batch gradient descent for a linear model in signed Q16.16. Load words (kind 0 weight,
// 1 feature, 2 target) are stored as they are accepted. A start word trains iteration_count
// iterations; each iteration computes the predictions, then the gradients, then the weight
// update through the bit-serial divider, one weight at a time. The weights then stream out
// from index nf (feature_count clamped to 8) down to the bias, which carries tlast.
// No further input word is taken until the last weight leaves.
// Depends on lrgd_pkg, lrgd_ctrl, lrgd_datapath and the assertion macro header.
`default_nettype none
`include "linear_regression_gradient_descent_top_macros.svh"
module linear_regression_gradient_descent_top import lrgd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // kind[1:0], sample_index[11:2],
                                      // feature_index[15:12], value[47:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // weight_index[3:0], weight_value[35:4], zero
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [15:0]      learning_rate, iteration_count;
  logic [3:0]       feature_count;
  logic [10:0]      sample_count;
  logic [FIdxW-1:0] nf;
  logic [10:0]      ns;
  logic             in_fire, out_fire, idle;
  lrgd_cmd_t        cmd;
  lrgd_stat_t       stat;
  logic [FIdxW-1:0] out_idx;
  logic signed [31:0] wval;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= 16'd1311;
      iteration_count <= 16'd900;
      feature_count <= 4'd1;
      sample_count <= 11'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_RATE: learning_rate <= pwdata[15:0];
        REG_ITER: iteration_count <= pwdata[15:0];
        REG_FEAT: feature_count <= pwdata[3:0];
        REG_SAMP: sample_count <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RATE: prdata = {16'd0, learning_rate};
      REG_ITER: prdata = {16'd0, iteration_count};
      REG_FEAT: prdata = {28'd0, feature_count};
      REG_SAMP: prdata = {21'd0, sample_count};
      default:  prdata = '0;
    endcase
  end

  // Clamped run sizes.
  assign nf = (feature_count > 4'(MaxFeatures)) ? 4'(MaxFeatures) : feature_count;
  assign ns = (sample_count == 11'd0) ? 11'd1 :
              (sample_count > 11'(MaxSamples)) ? 11'(MaxSamples) : sample_count;

  assign s_tready = idle;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  lrgd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .kind(s_tdata[1:0]),
    .iteration_count(iteration_count), .nf(nf), .ns(ns), .stat(stat),
    .out_fire(out_fire), .cmd(cmd), .idle(idle), .out_valid(m_tvalid), .out_idx(out_idx)
  );

  lrgd_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .kind(s_tdata[1:0]), .sample_index(s_tdata[11:2]),
    .feature_index(s_tdata[15:12]), .value(s_tdata[47:16]),
    .learning_rate(learning_rate), .ns(ns), .rd_idx(out_idx), .rd_weight(wval), .stat(stat)
  );

  assign m_tdata = {4'd0, wval, out_idx};
  assign m_tlast = (out_idx == 4'd0);

  // Checks on the controller and output sequencing.
  `LRGD_ASSERT(a_no_accept_busy, !(s_tready && m_tvalid), "input taken while emitting")
  `LRGD_ASSERT_NEXT(a_idx_down, out_fire && !m_tlast, m_tdata[3:0] == $past(m_tdata[3:0]) - 4'd1,
    "weight index not descending")
  `LRGD_ASSERT_NEXT(a_last_ends, out_fire && m_tlast, s_tready, "run did not end after bias")
endmodule
`default_nettype wire

@@ rtl/lrgd_div.sv @@
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// Depends on lrgd_pkg.
`default_nettype none
module lrgd_div import lrgd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] dividend,
  input  wire logic [26:0]        divisor,
  output logic                    busy,
  output logic signed [63:0]      quotient
);
  logic [63:0] q;
  logic [27:0] r;
  logic [6:0]  cnt;
  logic        neg;
  logic [27:0] trial;

  assign trial = {r[26:0], q[63]} - {1'b0, divisor};

  // One shift and subtract step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd64;
      neg  <= dividend[63];
      q    <= dividend[63] ? 64'(-dividend) : dividend;
      r    <= '0;
    end else if (busy) begin
      if (!trial[27]) begin
        r <= trial;
        q <= {q[62:0], 1'b1};
      end else begin
        r <= {r[26:0], q[63]};
        q <= {q[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

  assign quotient = neg ? -$signed(q) : $signed(q);
endmodule
`default_nettype wire

@@ rtl/lrgd_datapath.sv @@
// Stores, multiplier, accumulators and weight update of the regression block.
// Depends on lrgd_pkg and lrgd_div.
`default_nettype none
module lrgd_datapath import lrgd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lrgd_cmd_t          cmd,
  input  wire logic [1:0]         kind,
  input  wire logic [SIdxW-1:0]   sample_index,
  input  wire logic [FIdxW-1:0]   feature_index,
  input  wire logic signed [31:0] value,
  input  wire logic [15:0]        learning_rate,
  input  wire logic [10:0]        ns,
  input  wire logic [FIdxW-1:0]   rd_idx,
  output logic signed [31:0]      rd_weight,
  output lrgd_stat_t              stat
);
  logic signed [31:0] feature_store [MaxSamples*MaxFeatures];
  logic signed [31:0] target_store [MaxSamples];
  logic signed [31:0] pred_store [MaxSamples];
  logic signed [31:0] weights [MaxFeatures+1];
  logic signed [47:0] grad [MaxFeatures+1];
  logic signed [31:0] feat_q, targ_q, pred_q;
  // Wide enough for the bias plus eight full-scale shifted products.
  logic signed [51:0] acc;
  logic signed [32:0] err;
  logic signed [63:0] prod;
  logic signed [63:0] quotient;
  logic [FAddrW-1:0]  faddr, ld_faddr;
  logic               div_busy;
  logic signed [64:0] mul_p, mul_e;
  logic [FIdxW-1:0]   fjm1;

  assign fjm1     = cmd.fj - 4'd1;
  assign faddr    = {cmd.si, fjm1[2:0]};
  assign ld_faddr = {sample_index, 3'(feature_index - 4'd1)};

  // Memories: feature and target stores written by load words, predictions by wr_pred; read with registered data.
  always_ff @(posedge clk) begin
    if (cmd.load && kind == KIND_FEATURE && feature_index >= 4'd1 &&
        feature_index <= 4'(MaxFeatures))
      feature_store[ld_faddr] <= value;
    if (cmd.load && kind == KIND_TARGET) target_store[sample_index] <= value;
    if (cmd.wr_pred) pred_store[cmd.si] <= sat32(65'(acc));
    feat_q <= feature_store[faddr];
    targ_q <= target_store[cmd.si];
    pred_q <= pred_store[cmd.si];
  end

  // Multiplies with the registered feature, shifted down by 16 with floor.
  assign mul_p = 65'(weights[cmd.fj]) * 65'(feat_q);
  assign mul_e = 65'(err) * 65'(feat_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= MaxFeatures; k++) begin
        weights[k] <= '0;
        grad[k]    <= '0;
      end
    end else begin
      if (cmd.load && kind == KIND_WEIGHT && feature_index <= 4'(MaxFeatures))
        weights[feature_index] <= value;
      if (cmd.clr_grad)
        for (int k = 0; k <= MaxFeatures; k++) grad[k] <= '0;
      if (cmd.mac_grad) begin
        if (cmd.fj == 4'd0)
          grad[0] <= sat48(50'(grad[0]) + 50'(err));
        else
          grad[cmd.fj] <= sat48(50'(grad[cmd.fj]) + 50'(mul_e >>> 16));
      end
      if (cmd.wr_weight)
        weights[cmd.fj] <= sat32(65'(weights[cmd.fj]) - 65'(quotient));
    end
  end

  // Prediction accumulator, error and step product.
  always_ff @(posedge clk) begin
    if (cmd.clr_acc) acc <= 52'(weights[0]);
    else if (cmd.mac_pred) acc <= acc + 52'(mul_p >>> 16);
    if (cmd.err) err <= 33'(pred_q) - 33'(targ_q);
    if (cmd.upd_mul) prod <= 64'(grad[cmd.fj]) * $signed({1'b0, learning_rate});
  end

  lrgd_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(prod),
    .divisor({ns, 16'd0}), .busy(div_busy), .quotient(quotient)
  );

  assign stat.div_busy = div_busy;
  assign rd_weight = weights[rd_idx];
endmodule
`default_nettype wire

@@ rtl/lrgd_ctrl.sv @@
// Controller state machine sequencing loads, training loops and output.
// Depends on lrgd_pkg.
`default_nettype none
module lrgd_ctrl import lrgd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_fire,
  input  wire logic [1:0]         kind,
  input  wire logic [15:0]        iteration_count,
  input  wire logic [FIdxW-1:0]   nf,
  input  wire logic [10:0]        ns,
  input  wire lrgd_stat_t         stat,
  input  wire logic               out_fire,
  output lrgd_cmd_t               cmd,
  output logic                    idle,
  output logic                    out_valid,
  output logic [FIdxW-1:0]        out_idx
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PCLR  = 4'd1;
  localparam logic [3:0] S_PRD   = 4'd2;
  localparam logic [3:0] S_PMAC  = 4'd3;
  localparam logic [3:0] S_PWR   = 4'd4;
  localparam logic [3:0] S_ERD   = 4'd5;
  localparam logic [3:0] S_ELAT  = 4'd6;
  localparam logic [3:0] S_EERR  = 4'd7;
  localparam logic [3:0] S_GRD   = 4'd8;
  localparam logic [3:0] S_GMAC  = 4'd9;
  localparam logic [3:0] S_UMUL  = 4'd10;
  localparam logic [3:0] S_UDIV  = 4'd11;
  localparam logic [3:0] S_UWAIT = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]       state, state_next;
  logic [15:0]      it, it_next;
  logic [SIdxW:0]   si, si_next;
  logic [FIdxW-1:0] fj, fj_next;
  logic             last_s;

  assign last_s = (si + 11'd1 == ns);

  // Next state and commands.
  always_comb begin
    state_next = state;
    it_next = it;
    si_next = si;
    fj_next = fj;
    cmd = '0;
    cmd.si = si[SIdxW-1:0];
    cmd.fj = fj;
    cmd.load = in_fire && kind != KIND_START;
    case (state)
      S_IDLE: if (in_fire && kind == KIND_START) begin
        it_next = '0;
        fj_next = nf;
        state_next = (iteration_count == 16'd0) ? S_OUT : S_PCLR;
        si_next = '0;
      end
      S_PCLR: begin
        cmd.clr_acc = 1'b1;
        fj_next = 4'd1;
        state_next = (nf == 4'd0) ? S_PWR : S_PRD;
      end
      S_PRD: state_next = S_PMAC;
      S_PMAC: begin
        cmd.mac_pred = 1'b1;
        fj_next = fj + 4'd1;
        state_next = (fj == nf) ? S_PWR : S_PRD;
      end
      S_PWR: begin
        cmd.wr_pred = 1'b1;
        if (last_s) begin
          si_next = '0;
          state_next = S_ERD;
          cmd.clr_grad = 1'b1;
        end else begin
          si_next = si + 11'd1;
          state_next = S_PCLR;
        end
      end
      S_ERD: state_next = S_ELAT;
      S_ELAT: begin
        cmd.err = 1'b1;
        state_next = S_EERR;
      end
      S_EERR: begin
        cmd.fj = 4'd0;
        cmd.mac_grad = 1'b1;
        fj_next = 4'd1;
        state_next = (nf == 4'd0) ? S_GMAC : S_GRD;
      end
      S_GRD: state_next = S_GMAC;
      S_GMAC: begin
        cmd.mac_grad = (nf != 4'd0);
        fj_next = fj + 4'd1;
        if (nf == 4'd0 || fj == nf) begin
          if (last_s) begin
            fj_next = '0;
            state_next = S_UMUL;
          end else begin
            si_next = si + 11'd1;
            state_next = S_ERD;
          end
        end else state_next = S_GRD;
      end
      S_UMUL: begin
        cmd.upd_mul = 1'b1;
        state_next = S_UDIV;
      end
      S_UDIV: begin
        cmd.div_start = 1'b1;
        state_next = S_UWAIT;
      end
      S_UWAIT: if (!stat.div_busy) begin
        cmd.wr_weight = 1'b1;
        if (fj == nf) begin
          si_next = '0;
          if (it + 16'd1 == iteration_count) begin
            fj_next = nf;
            state_next = S_OUT;
          end else begin
            it_next = it + 16'd1;
            state_next = S_PCLR;
          end
        end else begin
          fj_next = fj + 4'd1;
          state_next = S_UMUL;
        end
      end
      S_OUT: if (out_fire) begin
        fj_next = fj - 4'd1;
        if (fj == 4'd0) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      it <= '0;
      si <= '0;
      fj <= '0;
    end else begin
      state <= state_next;
      it <= it_next;
      si <= si_next;
      fj <= fj_next;
    end
  end

  assign idle = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_idx = fj;
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking bench for the linear regression gradient descent block.
// Drives load and start words, programs the APB registers, and checks the trained weights.
// Depends on lrgd_pkg and linear_regression_gradient_descent_top.
`default_nettype none
module testbench import lrgd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         kind;
    logic [9:0]         si;
    logic [3:0]         fi;
    logic signed [31:0] val;
  } load_word_t;

  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic               last;
  } weight_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  linear_regression_gradient_descent_top DUT (.*);

  // Pending input words and trained weights still owed by the block.
  load_word_t   pending_words[$];
  weight_word_t trained_weights[$];
  int           errors = 0;
  int           pushed = 0;
  bit           calm = 1'b0;

  // Shadow of the registers and the training state.
  int unsigned        sh_rate = 1311, sh_iter = 900, sh_nf = 1, sh_ns = 1;
  logic signed [31:0] feat_mem[MaxSamples*MaxFeatures];
  logic signed [31:0] tgt_mem[MaxSamples];
  logic signed [31:0] pred_mem[MaxSamples];
  logic signed [31:0] wt[MaxFeatures+1];
  longint             grad[MaxFeatures+1];

  // Entries already queued for loading, so that training never reads an unwritten one.
  bit feat_ok[MaxSamples*MaxFeatures];
  bit tgt_ok[MaxSamples];

  initial forever #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint clip48(input longint v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return v;
  endfunction

  // Full training run followed by the weights from the top index down to the bias.
  function automatic void train_weights();
    int unsigned nf, ns;
    longint acc, e, stp;
    weight_word_t ww;
    nf = (sh_nf > MaxFeatures) ? MaxFeatures : sh_nf;
    ns = (sh_ns == 0) ? 1 : ((sh_ns > MaxSamples) ? MaxSamples : sh_ns);
    for (int unsigned it = 0; it < sh_iter; it++) begin
      for (int i = 0; i < ns; i++) begin
        acc = longint'(wt[0]);
        for (int j = 1; j <= nf; j++)
          acc += (longint'(wt[j]) * longint'(feat_mem[i*MaxFeatures+j-1])) >>> 16;
        pred_mem[i] = clip32(acc);
      end
      for (int j = 0; j <= nf; j++) grad[j] = 0;
      for (int i = 0; i < ns; i++) begin
        e = longint'(pred_mem[i]) - longint'(tgt_mem[i]);
        grad[0] = clip48(grad[0] + e);
        for (int j = 1; j <= nf; j++)
          grad[j] = clip48(grad[j] + ((e * longint'(feat_mem[i*MaxFeatures+j-1])) >>> 16));
      end
      for (int j = 0; j <= nf; j++) begin
        stp = (grad[j] * longint'(sh_rate)) / (longint'(ns) * 65536);
        wt[j] = clip32(longint'(wt[j]) - stp);
      end
    end
    for (int k = nf; k >= 0; k--) begin
      ww.idx = k[3:0];
      ww.val = wt[k];
      ww.last = (k == 0);
      trained_weights = {trained_weights, ww};
    end
  endfunction

  // Effect of one accepted input word.
  function automatic void apply_word(input load_word_t w);
    case (w.kind)
      KIND_WEIGHT: if (w.fi <= MaxFeatures) wt[w.fi] = w.val;
      KIND_FEATURE: if (w.fi >= 1 && w.fi <= MaxFeatures)
        feat_mem[w.si*MaxFeatures + w.fi - 1] = w.val;
      KIND_TARGET: tgt_mem[w.si] = w.val;
      default: train_weights();
    endcase
  endfunction

  // Driver: one word per handshake, with random gaps.
  load_word_t cur_word;
  int         send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) apply_word(cur_word);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          s_tdata <= {cur_word.val, cur_word.fi, cur_word.si, cur_word.kind};
          s_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 6);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls in bursts.
  int recv_stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      recv_stall = $urandom_range(0, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: compare each weight word with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (trained_weights.size() == 0) begin
        $display("%0t: unexpected word idx=%0d val=%h last=%b", $time,
                 m_tdata[3:0], m_tdata[35:4], m_tlast);
        errors++;
      end else begin
        weight_word_t ex;
        ex = trained_weights.pop_front();
        if (m_tdata[3:0] !== ex.idx || m_tdata[35:4] !== ex.val || m_tlast !== ex.last) begin
          $display("%0t: expected idx=%0d val=%h last=%b, got idx=%0d val=%h last=%b",
                   $time, ex.idx, ex.val, ex.last, m_tdata[3:0], m_tdata[35:4], m_tlast);
          errors++;
        end
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() != 0 || s_tvalid || trained_weights.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] r, input int unsigned v);
    wait_idle();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      REG_RATE: sh_rate = v & 16'hFFFF;
      REG_ITER: sh_iter = v & 16'hFFFF;
      REG_FEAT: sh_nf = v & 4'hF;
      default:  sh_ns = v & 11'h7FF;
    endcase
  endtask

  function automatic logic signed [31:0] pick_value(input int scale);
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 2*scale)) - scale;
    endcase
  endfunction

  function automatic void push_word(input logic [1:0] k, input int si, input int fi,
                                    input logic signed [31:0] v);
    load_word_t w;
    w.kind = k; w.si = si[9:0]; w.fi = fi[3:0]; w.val = v;
    pending_words = {pending_words, w};
    pushed++;
    if (k == KIND_FEATURE && fi >= 1 && fi <= MaxFeatures) feat_ok[si*MaxFeatures+fi-1] = 1;
    if (k == KIND_TARGET) tgt_ok[si] = 1;
  endfunction

  // Load whatever the next run reads but has never been written, then start it.
  function automatic void start_run();
    int unsigned nf, ns;
    nf = (sh_nf > MaxFeatures) ? MaxFeatures : sh_nf;
    ns = (sh_ns == 0) ? 1 : ((sh_ns > MaxSamples) ? MaxSamples : sh_ns);
    for (int i = 0; i < ns; i++) begin
      for (int j = 1; j <= nf; j++)
        if (!feat_ok[i*MaxFeatures+j-1]) push_word(KIND_FEATURE, i, j, pick_value(65536));
      if (!tgt_ok[i]) push_word(KIND_TARGET, i, $urandom_range(0, 15), pick_value(1 << 19));
    end
    push_word(KIND_START, $urandom_range(0, 1023), $urandom_range(0, 15), $urandom());
  endfunction

  // Random phase: new settings, a burst of loads with some ignored noise, then a start.
  task automatic random_phase();
    int n;
    write_reg(REG_RATE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(200, 6000));
    write_reg(REG_ITER, $urandom_range(0, 3));
    write_reg(REG_FEAT, ($urandom_range(0, 5) == 0) ? $urandom_range(9, 15)
                                                    : $urandom_range(0, 8));
    write_reg(REG_SAMP, $urandom_range(0, 5));
    n = $urandom_range(6, 16);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: push_word(KIND_WEIGHT, $urandom_range(0, 1023), $urandom_range(0, 8),
                           pick_value(1 << 17));
        3, 4, 5: push_word(KIND_FEATURE, $urandom_range(0, 7), $urandom_range(1, 8),
                           pick_value(65536));
        6: push_word(KIND_FEATURE, $urandom_range(0, 1023), $urandom_range(0, 15), $urandom());
        7: push_word(KIND_TARGET, $urandom_range(0, 1023), $urandom_range(0, 15), $urandom());
        8: push_word(KIND_TARGET, $urandom_range(0, 7), 0, pick_value(1 << 19));
        default: push_word(KIND_WEIGHT, 0, $urandom_range(9, 15), $urandom());
      endcase
    end
    start_run();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: bias and first weight at extremes, the rest random, ignored words, full feature count.
    write_reg(REG_RATE, 1311);
    write_reg(REG_ITER, 2);
    write_reg(REG_FEAT, 8);
    write_reg(REG_SAMP, 2);
    push_word(KIND_WEIGHT, 0, 0, 32'sh7FFF_FFFF);
    push_word(KIND_WEIGHT, 0, 1, 32'sh8000_0000);
    for (int j = 2; j <= MaxFeatures; j++) push_word(KIND_WEIGHT, 1023, j, pick_value(1 << 17));
    push_word(KIND_WEIGHT, 0, 15, 32'sh1234_5678);
    push_word(KIND_FEATURE, 0, 0, 32'sh7FFF_FFFF);
    push_word(KIND_FEATURE, 0, 9, 32'sh7FFF_FFFF);
    push_word(KIND_FEATURE, 1, 1, 32'sh8000_0000);
    push_word(KIND_TARGET, 1023, 15, 32'sh8000_0000);
    start_run();

    // Zero iterations returns the weights unchanged; largest step size.
    write_reg(REG_ITER, 0);
    write_reg(REG_RATE, 65535);
    start_run();

    // Count of zero for features and samples, then values above the limits.
    write_reg(REG_ITER, 3);
    write_reg(REG_FEAT, 0);
    write_reg(REG_SAMP, 0);
    start_run();
    write_reg(REG_FEAT, 15);
    write_reg(REG_SAMP, 1);
    write_reg(REG_RATE, 0);
    start_run();
    write_reg(REG_ITER, 65535);
    write_reg(REG_ITER, 1);
    write_reg(REG_FEAT, 0);
    write_reg(REG_SAMP, 2047);
    write_reg(REG_RATE, 4000);
    start_run();

    // Random phases; the sender also holds off until everything is back.
    while (pushed < 210) begin
      if (pushed > 170) calm = 1'b1;
      random_phase();
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
